// ----- rtl/cpa_pkg.sv -----
// Package with the shared types and constants of the partition allocator.
`timescale 1ns / 1ps
package cpa_pkg;

  localparam int ADDR_BITS          = 20;
  localparam int SIZE_BITS          = ADDR_BITS + 1;
  localparam int PID_BITS           = 16;
  localparam int MAX_PARTITIONS_DEF = 32;

  localparam logic [SIZE_BITS-1:0] MEM_MAX   = SIZE_BITS'(1) << ADDR_BITS;
  localparam logic [SIZE_BITS-1:0] MEM_RESET = SIZE_BITS'(4096);

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic REG_FIT_POLICY   = 1'b0;
  localparam logic REG_MEMORY_BYTES = 1'b1;

  localparam logic CMD_ALLOCATE = 1'b0;
  localparam logic CMD_RELEASE  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_NOOWNER = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    logic                 cmd;
    logic [PID_BITS-1:0]  process_id;
    logic [SIZE_BITS-1:0] request_bytes;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic [ADDR_BITS-1:0] span_base;
    logic [ADDR_BITS-1:0] span_last;
  } rsp_t;

  typedef struct packed {
    logic    load;
    logic    scan_step;
    logic    alloc_commit;
    logic    rel_mark;
    logic    merge_step;
    logic    merge_commit;
    logic    finish;
    status_t fin_status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic is_release;
    logic req_zero;
    logic hit;
    logic need_tail;
    logic have_unused;
  } dp_stat_t;

endpackage

// ----- rtl/cpa_datapath.sv -----
// Datapath of the partition allocator: partition table, scan trackers and result register.
`timescale 1ns / 1ps
module cpa_datapath import cpa_pkg::*; #(
  parameter int MAX_PARTITIONS = MAX_PARTITIONS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  req_t                 req,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [SIZE_BITS-1:0] cfg_data,
  input  ctrl_cmd_t            ctrl,
  output dp_stat_t             stat,
  output logic                 done,
  output rsp_t                 rsp
);

  localparam int IDX_W = $clog2(MAX_PARTITIONS);

  logic                 e_valid [MAX_PARTITIONS];
  logic                 e_busy  [MAX_PARTITIONS];
  logic [ADDR_BITS-1:0] e_base  [MAX_PARTITIONS];
  logic [SIZE_BITS-1:0] e_size  [MAX_PARTITIONS];
  logic [PID_BITS-1:0]  e_owner [MAX_PARTITIONS];

  logic [IDX_W-1:0]     idx;
  logic                 cur_cmd;
  logic [PID_BITS-1:0]  cur_pid;
  logic [SIZE_BITS-1:0] cur_req;
  logic [1:0]           fit;
  logic                 hit;
  logic [IDX_W-1:0]     b_idx;
  logic [ADDR_BITS-1:0] b_base;
  logic [SIZE_BITS-1:0] b_size;
  logic                 un_found;
  logic [IDX_W-1:0]     un_idx;
  logic                 l_found;
  logic [IDX_W-1:0]     l_idx;
  logic [ADDR_BITS-1:0] l_base;
  logic [SIZE_BITS-1:0] l_size;
  logic                 rt_found;
  logic [IDX_W-1:0]     rt_idx;
  logic [SIZE_BITS-1:0] rt_size;

  logic                 c_valid;
  logic                 c_busy;
  logic [ADDR_BITS-1:0] c_base;
  logic [SIZE_BITS-1:0] c_size;
  logic [PID_BITS-1:0]  c_owner;
  logic [SIZE_BITS-1:0] c_end;
  logic [SIZE_BITS-1:0] r_end;
  logic                 take;
  logic [SIZE_BITS-1:0] mem_val;

  assign c_valid = e_valid[idx];
  assign c_busy  = e_busy[idx];
  assign c_base  = e_base[idx];
  assign c_size  = e_size[idx];
  assign c_owner = e_owner[idx];
  assign c_end   = {1'b0, c_base} + c_size;
  assign r_end   = {1'b0, b_base} + b_size;

  always_comb begin
    take = 1'b0;
    if (cur_cmd == CMD_RELEASE) begin
      take = c_valid && c_busy && (c_owner == cur_pid) && (!hit || c_base < b_base);
    end else if (c_valid && !c_busy && c_size >= cur_req) begin
      if (!hit) begin
        take = 1'b1;
      end else begin
        case (fit)
          FIT_BEST:  take = (c_size < b_size) || (c_size == b_size && c_base < b_base);
          FIT_WORST: take = (c_size > b_size) || (c_size == b_size && c_base < b_base);
          default:   take = c_base < b_base;
        endcase
      end
    end
  end

  always_comb begin
    mem_val = cfg_data;
    if (cfg_data == '0) begin
      mem_val = SIZE_BITS'(1);
    end else if (cfg_data > MEM_MAX) begin
      mem_val = MEM_MAX;
    end
  end

  assign stat.idx_last    = (idx == IDX_W'(MAX_PARTITIONS - 1));
  assign stat.is_release  = (cur_cmd == CMD_RELEASE);
  assign stat.req_zero    = (cur_req == '0);
  assign stat.hit         = hit;
  assign stat.need_tail   = (b_size > cur_req);
  assign stat.have_unused = un_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit  <= FIT_FIRST;
      done <= 1'b0;
      idx  <= '0;
    end else begin
      done <= ctrl.finish;
      if (cfg_we && cfg_index == REG_FIT_POLICY) begin
        fit <= cfg_data[1:0];
      end
      if (ctrl.load || ctrl.rel_mark) begin
        idx <= '0;
      end else if (ctrl.scan_step || ctrl.merge_step) begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cur_cmd  <= req.cmd;
      cur_pid  <= req.process_id;
      cur_req  <= req.request_bytes;
      hit      <= 1'b0;
      un_found <= 1'b0;
    end
    if (ctrl.scan_step) begin
      if (take) begin
        hit    <= 1'b1;
        b_idx  <= idx;
        b_base <= c_base;
        b_size <= c_size;
      end
      if (!c_valid && !un_found) begin
        un_found <= 1'b1;
        un_idx   <= idx;
      end
    end
    if (ctrl.rel_mark) begin
      l_found  <= 1'b0;
      rt_found <= 1'b0;
    end
    if (ctrl.merge_step && idx != b_idx && c_valid && !c_busy) begin
      if (!l_found && c_end == {1'b0, b_base}) begin
        l_found <= 1'b1;
        l_idx   <= idx;
        l_base  <= c_base;
        l_size  <= c_size;
      end
      if (!rt_found && {1'b0, c_base} == r_end) begin
        rt_found <= 1'b1;
        rt_idx   <= idx;
        rt_size  <= c_size;
      end
    end
    if (ctrl.finish) begin
      rsp.status    <= ctrl.fin_status;
      rsp.span_base <= '0;
      rsp.span_last <= '0;
      if (ctrl.fin_status == ST_DONE) begin
        rsp.span_base <= b_base;
        if (cur_cmd == CMD_RELEASE) begin
          rsp.span_last <= b_base + b_size[ADDR_BITS-1:0] - ADDR_BITS'(1);
        end else begin
          rsp.span_last <= b_base + cur_req[ADDR_BITS-1:0] - ADDR_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (cfg_we && cfg_index == REG_MEMORY_BYTES)) begin
      for (int i = 0; i < MAX_PARTITIONS; i++) begin
        e_valid[i] <= (i == 0);
        e_busy[i]  <= 1'b0;
      end
      e_base[0]  <= '0;
      e_size[0]  <= rst ? MEM_RESET : mem_val;
      e_owner[0] <= '0;
    end else begin
      if (ctrl.alloc_commit) begin
        if (b_size > cur_req) begin
          e_valid[un_idx] <= 1'b1;
          e_busy[un_idx]  <= 1'b0;
          e_owner[un_idx] <= '0;
          e_base[un_idx]  <= b_base + cur_req[ADDR_BITS-1:0];
          e_size[un_idx]  <= b_size - cur_req;
        end
        e_size[b_idx]  <= cur_req;
        e_busy[b_idx]  <= 1'b1;
        e_owner[b_idx] <= cur_pid;
      end
      if (ctrl.rel_mark) begin
        e_busy[b_idx]  <= 1'b0;
        e_owner[b_idx] <= '0;
      end
      if (ctrl.merge_commit) begin
        e_base[b_idx] <= l_found ? l_base : b_base;
        e_size[b_idx] <= b_size + (l_found ? l_size : '0) + (rt_found ? rt_size : '0);
        if (l_found) begin
          e_valid[l_idx] <= 1'b0;
        end
        if (rt_found) begin
          e_valid[rt_idx] <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- rtl/cpa_controller.sv -----
// Controller state machine that sequences the table scans of the partition allocator.
`timescale 1ns / 1ps
module cpa_controller import cpa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  dp_stat_t  stat,
  output ctrl_cmd_t ctrl,
  output logic      busy
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_EVAL  = 5'b00100,
    S_MSCAN = 5'b01000,
    S_MERGE = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    ctrl       = '0;
    ctrl.fin_status = ST_DONE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctrl.load  = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        ctrl.scan_step = 1'b1;
        if (stat.idx_last) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        state_next = S_IDLE;
        ctrl.finish = 1'b1;
        if (stat.is_release) begin
          if (!stat.hit) begin
            ctrl.fin_status = ST_NOOWNER;
          end else begin
            ctrl.finish   = 1'b0;
            ctrl.rel_mark = 1'b1;
            state_next    = S_MSCAN;
          end
        end else if (stat.req_zero || !stat.hit) begin
          ctrl.fin_status = ST_NOFIT;
        end else if (stat.need_tail && !stat.have_unused) begin
          ctrl.fin_status = ST_FULL;
        end else begin
          ctrl.alloc_commit = 1'b1;
        end
      end
      S_MSCAN: begin
        ctrl.merge_step = 1'b1;
        if (stat.idx_last) begin
          state_next = S_MERGE;
        end
      end
      S_MERGE: begin
        ctrl.merge_commit = 1'b1;
        ctrl.finish       = 1'b1;
        state_next        = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/contiguous_partition_allocator_unit.sv -----
// Top level of the contiguous partition allocator.
//
// An item (allocate or release) is taken when start is high and busy is low.
// Allocate picks a free partition by the fit policy, marks its head occupied
// and splits the remainder into a new free entry. Release frees the lowest
// occupied partition of the process and merges it with free neighbors.
// Each item gives one result, shown on rsp for one cycle with done high.
// An allocate makes one pass over the table through a single read port,
// then commits the result in the evaluate state. A release that finds
// its owner makes a second pass that looks for the neighbors to merge.
// Busy falls in the cycle done is shown, so the next item may start then.
// The receiver cannot stall results. Configuration writes are taken at
// once while idle; writing memory_bytes rebuilds the table as one free
// partition. Reset selects first fit and a 4096 byte memory; the table
// is ready in the cycle after reset.
`timescale 1ns / 1ps
module contiguous_partition_allocator_unit import cpa_pkg::*; #(
  parameter int MAX_PARTITIONS = MAX_PARTITIONS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  req_t                 req,
  output logic                 done,
  output rsp_t                 rsp,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [SIZE_BITS-1:0] cfg_data
);

  ctrl_cmd_t ctrl;
  dp_stat_t  stat;

  cpa_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  cpa_datapath #(
    .MAX_PARTITIONS(MAX_PARTITIONS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctrl      (ctrl),
    .stat      (stat),
    .done      (done),
    .rsp       (rsp)
  );

endmodule

// ----- rtl/cpa_checker.sv -----
// Port checker for the partition allocator and its bind to the top level.
`timescale 1ns / 1ps
module cpa_checker import cpa_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input rsp_t rsp
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("Block not busy after an item was accepted.");

  a_no_early_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("Result shown in the cycle right after acceptance.");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("Result shown while the block is still busy.");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != ST_DONE) |-> (rsp.span_base == '0 && rsp.span_last == '0))
    else $error("Failed item carries a nonzero span.");

endmodule

bind contiguous_partition_allocator_unit cpa_checker u_cpa_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

// ----- bench/contiguous_partition_allocator_unit_check.sv -----
// Checker that predicts and compares the results of the partition allocator.
`timescale 1ns / 1ps
module contiguous_partition_allocator_unit_check import cpa_pkg::*; #(
  parameter int NPART = MAX_PARTITIONS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  req_t                 req,
  input  logic                 done,
  input  rsp_t                 rsp,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [SIZE_BITS-1:0] cfg_data,
  output int                   errors,
  output int                   pending,
  output int                   results_seen
);

  logic [1:0]           policy;
  logic [SIZE_BITS-1:0] mem_bytes;
  logic                 pv [NPART];
  logic [SIZE_BITS-1:0] pbase [NPART];
  logic [SIZE_BITS-1:0] psize [NPART];
  logic                 pbusy [NPART];
  logic [PID_BITS-1:0]  powner [NPART];
  rsp_t                 awaited [$];

  assign pending = awaited.size();

  function automatic void rebuild_table();
    for (int i = 0; i < NPART; i++) begin
      pv[i] = 1'b0;
      pbase[i] = '0;
      psize[i] = '0;
      pbusy[i] = 1'b0;
      powner[i] = '0;
    end
    pv[0] = 1'b1;
    psize[0] = mem_bytes;
  endfunction

  function automatic rsp_t allocate_span(logic [PID_BITS-1:0] pid, logic [SIZE_BITS-1:0] n);
    rsp_t r;
    int c;
    int t;
    logic take;
    r = '0;
    r.status = ST_NOFIT;
    c = -1;
    t = -1;
    if (n == 0) return r;
    for (int i = 0; i < NPART; i++) begin
      if (!pv[i] || pbusy[i] || psize[i] < n) continue;
      if (c < 0) begin
        c = i;
        continue;
      end
      if (policy == FIT_BEST)
        take = psize[i] < psize[c] || (psize[i] == psize[c] && pbase[i] < pbase[c]);
      else if (policy == FIT_WORST)
        take = psize[i] > psize[c] || (psize[i] == psize[c] && pbase[i] < pbase[c]);
      else
        take = pbase[i] < pbase[c];
      if (take) c = i;
    end
    if (c < 0) return r;
    if (psize[c] > n) begin
      for (int i = NPART - 1; i >= 0; i--)
        if (!pv[i]) t = i;
      if (t < 0) begin
        r.status = ST_FULL;
        return r;
      end
      pv[t] = 1'b1;
      pbusy[t] = 1'b0;
      powner[t] = '0;
      pbase[t] = pbase[c] + n;
      psize[t] = psize[c] - n;
    end
    psize[c] = n;
    pbusy[c] = 1'b1;
    powner[c] = pid;
    r.status = ST_DONE;
    r.span_base = pbase[c][ADDR_BITS-1:0];
    r.span_last = ADDR_BITS'(pbase[c] + n - 1);
    return r;
  endfunction

  function automatic rsp_t release_span(logic [PID_BITS-1:0] pid);
    rsp_t r;
    int k;
    r = '0;
    k = -1;
    for (int i = 0; i < NPART; i++)
      if (pv[i] && pbusy[i] && powner[i] == pid && (k < 0 || pbase[i] < pbase[k])) k = i;
    if (k < 0) begin
      r.status = ST_NOOWNER;
      return r;
    end
    r.status = ST_DONE;
    r.span_base = pbase[k][ADDR_BITS-1:0];
    r.span_last = ADDR_BITS'(pbase[k] + psize[k] - 1);
    pbusy[k] = 1'b0;
    powner[k] = '0;
    for (int i = 0; i < NPART; i++) begin
      if (i == k || !pv[i] || pbusy[i]) continue;
      if (pbase[i] + psize[i] == pbase[k]) begin
        pbase[k] = pbase[i];
        psize[k] = psize[k] + psize[i];
        pv[i] = 1'b0;
        psize[i] = '0;
        pbase[i] = '0;
        break;
      end
    end
    for (int i = 0; i < NPART; i++) begin
      if (i == k || !pv[i] || pbusy[i]) continue;
      if (pbase[k] + psize[k] == pbase[i]) begin
        psize[k] = psize[k] + psize[i];
        pv[i] = 1'b0;
        psize[i] = '0;
        pbase[i] = '0;
        break;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_t e;
    if (rst) begin
      policy = FIT_FIRST;
      mem_bytes = MEM_RESET;
      rebuild_table();
      awaited.delete();
      errors = 0;
      results_seen = 0;
    end else begin
      if (done) begin
        results_seen = results_seen + 1;
        if (awaited.size() == 0) begin
          errors = errors + 1;
          $display("%0t: unexpected result %p", $time, rsp);
        end else begin
          e = awaited.pop_front();
          if (rsp.status !== e.status || rsp.span_base !== e.span_base ||
              rsp.span_last !== e.span_last) begin
            errors = errors + 1;
            $display("%0t: expected %s %0h..%0h, got %s %0h..%0h", $time,
                     e.status.name(), e.span_base, e.span_last,
                     rsp.status.name(), rsp.span_base, rsp.span_last);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_FIT_POLICY) begin
          policy = cfg_data[1:0];
        end else begin
          mem_bytes = cfg_data;
          if (mem_bytes == '0) mem_bytes = SIZE_BITS'(1);
          if (mem_bytes > MEM_MAX) mem_bytes = MEM_MAX;
          rebuild_table();
        end
      end
      if (start && !busy) begin
        if (req.cmd == CMD_ALLOCATE) awaited.push_back(allocate_span(req.process_id, req.request_bytes));
        else awaited.push_back(release_span(req.process_id));
      end
    end
  end

endmodule

// ----- bench/contiguous_partition_allocator_unit_test.sv -----
// Testbench top: drives items and configuration into the allocator and reports the verdict.
`timescale 1ns / 1ps
module contiguous_partition_allocator_unit_test;
  import cpa_pkg::*;

  localparam int LIMIT = 2000000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  req_t                 req = '0;
  logic                 done;
  rsp_t                 rsp;
  logic                 cfg_we = 1'b0;
  logic                 cfg_index = 1'b0;
  logic [SIZE_BITS-1:0] cfg_data = '0;
  int                   errors;
  int                   pending;
  int                   results_seen;
  int                   cycles = 0;
  int                   items_sent = 0;
  int                   calm = 0;
  logic [PID_BITS-1:0]  pids [8];

  always #10 clk = ~clk;

  contiguous_partition_allocator_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  contiguous_partition_allocator_unit_check checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .results_seen(results_seen)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic [SIZE_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(input logic c, input logic [PID_BITS-1:0] pid,
                           input logic [SIZE_BITS-1:0] n);
    if (calm == 0)
      while ($urandom_range(99) < 23) begin
        start <= 1'b0;
        @(posedge clk);
      end
    start <= 1'b1;
    req <= '{cmd: c, process_id: pid, request_bytes: n};
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [SIZE_BITS-1:0] pick_size(logic [SIZE_BITS-1:0] mem);
    case ($urandom_range(9))
      0: return SIZE_BITS'($urandom);
      1: return mem;
      2: return '0;
      default: return SIZE_BITS'($urandom_range(1, mem / 6 + 1));
    endcase
  endfunction

  initial begin
    logic [SIZE_BITS-1:0] mem;
    logic [1:0] pol;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(CMD_ALLOCATE, 16'h0000, 21'd0);
    send_item(CMD_ALLOCATE, 16'hFFFF, 21'd100);
    send_item(CMD_ALLOCATE, 16'hFFFF, 21'd100);
    send_item(CMD_ALLOCATE, 16'h0001, 21'd5000);
    send_item(CMD_ALLOCATE, 16'h0002, 21'd3896);
    send_item(CMD_RELEASE, 16'hFFFF, 21'h1FFFFF);
    send_item(CMD_RELEASE, 16'h1234, 21'd0);
    send_item(CMD_RELEASE, 16'h0002, 21'd0);
    send_item(CMD_RELEASE, 16'hFFFF, 21'd0);
    send_item(CMD_ALLOCATE, 16'h0003, 21'd4096);
    send_item(CMD_RELEASE, 16'h0003, 21'd0);
    drain();
    write_reg(REG_MEMORY_BYTES, 21'd40);
    write_reg(REG_FIT_POLICY, SIZE_BITS'(FIT_FIRST));
    for (int i = 0; i < 33; i++) send_item(CMD_ALLOCATE, 16'(i), 21'd1);
    send_item(CMD_RELEASE, 16'd39, 21'd0);
    drain();
    write_reg(REG_MEMORY_BYTES, 21'd0);
    send_item(CMD_ALLOCATE, 16'h0007, 21'd1);
    drain();
    write_reg(REG_MEMORY_BYTES, 21'h1FFFFF);
    send_item(CMD_ALLOCATE, 16'h0008, 21'h100000);
    send_item(CMD_ALLOCATE, 16'h0009, 21'h1FFFFF);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      pol = (ph < 4) ? 2'(ph) : 2'($urandom_range(3));
      case (ph % 4)
        0: mem = 21'd4096;
        1: mem = MEM_MAX;
        2: mem = 21'($urandom_range(1, 300));
        default: mem = 21'($urandom_range(1, 1 << 20));
      endcase
      write_reg(REG_FIT_POLICY, SIZE_BITS'(pol));
      write_reg(REG_MEMORY_BYTES, mem);
      for (int i = 0; i < 8; i++) pids[i] = 16'($urandom);
      calm = (ph == 5) ? 1 : 0;
      for (int k = 0; k < 125; k++) begin
        if ($urandom_range(99) < 55)
          send_item(CMD_ALLOCATE, pids[$urandom_range(7)], pick_size(mem));
        else
          send_item(CMD_RELEASE, ($urandom_range(9) == 0) ? 16'($urandom) : pids[$urandom_range(7)],
                    21'($urandom));
      end
      drain();
    end

    $display("Sent %0d items across all fit policies and memory sizes; %0d results checked.",
             items_sent, results_seen);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/cpa_pkg.sv
rtl/cpa_datapath.sv
rtl/cpa_controller.sv
rtl/contiguous_partition_allocator_unit.sv
rtl/cpa_checker.sv
bench/contiguous_partition_allocator_unit_check.sv
bench/contiguous_partition_allocator_unit_test.sv
